@@ hdl/dcbl_pkg.sv @@
// ----------------------------------------------------------------------------
// dcbl_pkg
// Shared types and constants of the dc blocker / level meter / capture core.
// ----------------------------------------------------------------------------
package dcbl_pkg;

  localparam int unsigned SAMPLE_W          = 16;
  localparam int unsigned IDX_W             = 20;
  localparam int unsigned SHIFT_W           = 4;
  localparam int unsigned ACC_W             = 32;
  localparam int unsigned SUM_W             = 24;
  localparam int unsigned CFG_IDX_W         = 1;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned BLOCK_MAX_DEFAULT = 256;

  localparam logic [IDX_W-1:0]   MAX_SAMPLES_RST  = 20'd960000;
  localparam logic [SHIFT_W-1:0] FILTER_SHIFT_RST = 4'd10;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_START  = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SAMPLES  = 1'b0,
    CFG_FILTER_SHIFT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_SUM,
    ST_METER,
    ST_DIV
  } back_state_e;

  typedef struct packed {
    cmd_e                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   max_samples;
    logic [SHIFT_W-1:0] filter_shift;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_sample;
    logic                       stored;
    logic [IDX_W-1:0]           write_index;
    logic                       level_valid;
    logic [SAMPLE_W-1:0]        level;
    logic [SAMPLE_W-1:0]        peak;
    logic                       limit_reached;
    logic                       recording;
  } result_t;

endpackage

@@ hdl/dcbl_front.sv @@
// ----------------------------------------------------------------------------
// dcbl_front
// Input side: takes items, decodes the command and holds them in a short
// queue until the back end picks them up.
// ----------------------------------------------------------------------------
module dcbl_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          command_i,
  input  logic signed [dcbl_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic                                last_in_block_i,
  output logic                                item_valid_o,
  output dcbl_pkg::item_t                     item_o,
  input  logic                                item_pop_i
);
  import dcbl_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;
  item_t            item_new;

  assign full         = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign do_push      = push && !full;
  assign do_pop       = item_pop_i && item_valid_o;

  always_comb begin
    item_new.cmd    = cmd_e'(command_i);
    item_new.sample = sample_in_i;
    item_new.last   = last_in_block_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

@@ hdl/dcbl_div.sv @@
// ----------------------------------------------------------------------------
// dcbl_div
// Restoring divider, one quotient bit per cycle, for the block mean level.
// ----------------------------------------------------------------------------
module dcbl_div #(
  parameter int unsigned DIVISOR_W = 9
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [dcbl_pkg::SUM_W-1:0]   dividend_i,
  input  logic [DIVISOR_W-1:0]         divisor_i,
  output logic                         done_o,
  output logic [dcbl_pkg::SUM_W-1:0]   quotient_o
);
  import dcbl_pkg::*;

  localparam int unsigned STEP_W = $clog2(SUM_W);

  logic                  busy_q;
  logic                  done_q;
  logic [STEP_W-1:0]     step_q;
  logic [SUM_W-1:0]      quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  den_q;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign rem_sh     = {rem_q, quo_q[SUM_W-1]};
  assign diff       = rem_sh - {1'b0, den_q};
  assign fits       = !diff[DIVISOR_W];
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

endmodule

@@ hdl/dcbl_back.sv @@
// ----------------------------------------------------------------------------
// dcbl_back
// Execution side: dc blocking filter, block meter, capture addressing and
// the result register.
// ----------------------------------------------------------------------------
module dcbl_back #(
  parameter int unsigned BLOCK_MAX = dcbl_pkg::BLOCK_MAX_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dcbl_pkg::cfg_t    cfg_i,
  input  logic              item_valid_i,
  input  dcbl_pkg::item_t   item_i,
  output logic              item_pop_o,
  output logic              res_valid_o,
  output dcbl_pkg::result_t res_o,
  input  logic              res_pop_i
);
  import dcbl_pkg::*;

  localparam int unsigned CNT_W = $clog2(BLOCK_MAX + 1);

  back_state_e               state_q, state_d;
  logic [ACC_W-1:0]          prev_in_q, prev_in_d;
  logic [ACC_W-1:0]          prev_out_q, prev_out_d;
  logic [SUM_W-1:0]          sum_q, sum_d;
  logic [SAMPLE_W-1:0]       peak_q, peak_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [IDX_W-1:0]          stored_cnt_q, stored_cnt_d;
  logic                      rec_q, rec_d;
  logic                      limit_q, limit_d;

  logic signed [SAMPLE_W-1:0] x_q, x_d;
  logic                       last_q, last_d;
  logic [ACC_W-1:0]           d_q, d_d;
  logic [ACC_W-1:0]           fb_q, fb_d;
  logic [SAMPLE_W-1:0]        pcm_q, pcm_d;
  logic                       stored_q, stored_d;
  logic [IDX_W-1:0]           wr_q, wr_d;
  logic [SAMPLE_W-1:0]        pk_q, pk_d;

  logic                       res_valid_q;
  result_t                    res_q;
  result_t                    res_new;
  result_t                    res_base;
  logic                       res_load;

  logic [ACC_W-1:0]           x_ext;
  logic [ACC_W-1:0]           asr;
  logic [ACC_W-1:0]           y;
  logic [SAMPLE_W-1:0]        mag;
  logic [SUM_W:0]             sum_ext;
  logic [SUM_W-1:0]           sum_sat;
  logic [SAMPLE_W-1:0]        peak_new;
  logic [CNT_W-1:0]           cnt_inc;
  logic                       close;
  logic [IDX_W-1:0]           stored_cnt_new;

  logic                       div_start;
  logic                       div_done;
  logic [SUM_W-1:0]           div_quo;

  assign x_ext    = {x_q, 16'h0000};
  assign asr      = ACC_W'($signed(prev_out_q) >>> cfg_i.filter_shift);
  assign y        = d_q + fb_q;
  assign mag      = pcm_q[SAMPLE_W-1] ? SAMPLE_W'(-pcm_q) : pcm_q;
  assign sum_ext  = {1'b0, sum_q} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, mag};
  assign sum_sat  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
  assign peak_new = (mag > peak_q) ? mag : peak_q;
  assign cnt_inc  = cnt_q + 1'b1;
  assign close    = last_q || (cnt_inc >= CNT_W'(BLOCK_MAX));

  always_comb begin
    res_base                 = '0;
    res_base.filtered_sample = pcm_q;
    res_base.stored          = stored_q;
    res_base.write_index     = stored_q ? wr_q : '0;
    res_base.limit_reached   = limit_q;
    res_base.recording       = rec_q;
  end

  always_comb begin
    state_d        = state_q;
    prev_in_d      = prev_in_q;
    prev_out_d     = prev_out_q;
    sum_d          = sum_q;
    peak_d         = peak_q;
    cnt_d          = cnt_q;
    stored_cnt_d   = stored_cnt_q;
    rec_d          = rec_q;
    limit_d        = limit_q;
    x_d            = x_q;
    last_d         = last_q;
    d_d            = d_q;
    fb_d           = fb_q;
    pcm_d          = pcm_q;
    stored_d       = stored_q;
    wr_d           = wr_q;
    pk_d           = pk_q;
    item_pop_o     = 1'b0;
    res_load       = 1'b0;
    res_new        = res_base;
    div_start      = 1'b0;
    stored_cnt_new = stored_cnt_q;

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i && !res_valid_q) begin
          item_pop_o            = 1'b1;
          res_new               = '0;
          res_new.limit_reached = limit_q;
          res_new.recording     = rec_q;
          case (item_i.cmd)
            CMD_START: begin
              prev_in_d             = '0;
              prev_out_d            = '0;
              sum_d                 = '0;
              peak_d                = '0;
              cnt_d                 = '0;
              stored_cnt_d          = '0;
              limit_d               = 1'b0;
              rec_d                 = 1'b1;
              res_new.limit_reached = 1'b0;
              res_new.recording     = 1'b1;
              res_load              = 1'b1;
            end
            CMD_STOP: begin
              rec_d             = 1'b0;
              res_new.recording = 1'b0;
              res_load          = 1'b1;
            end
            CMD_SAMPLE: begin
              if (rec_q) begin
                x_d     = item_i.sample;
                last_d  = item_i.last;
                state_d = ST_FILT;
              end else begin
                res_load = 1'b1;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_FILT: begin
        d_d     = x_ext - prev_in_q;
        fb_d    = prev_out_q - asr;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        prev_in_d  = x_ext;
        prev_out_d = y;
        pcm_d      = y[ACC_W-1 -: SAMPLE_W];
        stored_d   = (stored_cnt_q < cfg_i.max_samples);
        wr_d       = stored_cnt_q;
        if (stored_cnt_q < cfg_i.max_samples) begin
          stored_cnt_new = stored_cnt_q + 1'b1;
        end
        stored_cnt_d = stored_cnt_new;
        if (stored_cnt_new >= cfg_i.max_samples) begin
          limit_d = 1'b1;
          rec_d   = 1'b0;
        end
        state_d = ST_METER;
      end
      ST_METER: begin
        if (close) begin
          sum_d     = '0;
          peak_d    = '0;
          cnt_d     = '0;
          pk_d      = peak_new;
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          sum_d    = sum_sat;
          peak_d   = peak_new;
          cnt_d    = cnt_inc;
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_new.level_valid = 1'b1;
          res_new.level       = div_quo[SAMPLE_W-1:0];
          res_new.peak        = pk_q;
          res_load            = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  dcbl_div #(
    .DIVISOR_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_sat),
    .divisor_i  (cnt_inc),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prev_in_q    <= '0;
      prev_out_q   <= '0;
      sum_q        <= '0;
      peak_q       <= '0;
      cnt_q        <= '0;
      stored_cnt_q <= '0;
      rec_q        <= 1'b0;
      limit_q      <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      prev_in_q    <= prev_in_d;
      prev_out_q   <= prev_out_d;
      sum_q        <= sum_d;
      peak_q       <= peak_d;
      cnt_q        <= cnt_d;
      stored_cnt_q <= stored_cnt_d;
      rec_q        <= rec_d;
      limit_q      <= limit_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    last_q   <= last_d;
    d_q      <= d_d;
    fb_q     <= fb_d;
    pcm_q    <= pcm_d;
    stored_q <= stored_d;
    wr_q     <= wr_d;
    pk_q     <= pk_d;
    if (res_load) begin
      res_q <= res_new;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // back end only works while the result slot is free
  a_busy_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !res_valid_q)
    else $error("back end busy while a result waits");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> res_valid_q)
    else $error("loaded result not presented");

  a_block_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_W'(BLOCK_MAX))
    else $error("block count beyond block size");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside division state");

endmodule

@@ hdl/dc_blocker_level_meter_capture_core.sv @@
// A recording item (command 0 while recording) runs through the back end in
// steps: filter difference terms, filter sum, metering and result load.
// When the item closes a block, the mean level comes from a 24-step serial
// divider before the result load. Start, stop, unused commands and samples
// taken while not recording load their result straight from the idle state.
// A two-entry input queue and a one-entry result register let the input side
// keep taking items while a result waits to be popped. Configuration writes
// are always ready and reach the back end even while an item is in progress.
// ----------------------------------------------------------------------------
// dc_blocker_level_meter_capture_core
// Q16 dc blocking high-pass filter with per-block peak and mean level and
// capture memory addressing up to a programmable sample limit.
// ----------------------------------------------------------------------------
module dc_blocker_level_meter_capture_core #(
  parameter int unsigned BLOCK_MAX = dcbl_pkg::BLOCK_MAX_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dcbl_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [dcbl_pkg::IDX_W-1:0]            cfg_data_i,
  input  logic                                  push,
  output logic                                  full,
  input  logic [1:0]                            command_i,
  input  logic signed [dcbl_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic                                  last_in_block_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [dcbl_pkg::SAMPLE_W-1:0]  filtered_sample_o,
  output logic                                  stored_o,
  output logic [dcbl_pkg::IDX_W-1:0]            write_index_o,
  output logic                                  level_valid_o,
  output logic [dcbl_pkg::SAMPLE_W-1:0]         level_o,
  output logic [dcbl_pkg::SAMPLE_W-1:0]         peak_o,
  output logic                                  limit_reached_o,
  output logic                                  recording_o
);
  import dcbl_pkg::*;

  cfg_t    cfg_q;
  item_t   item;
  logic    item_valid;
  logic    item_pop;
  logic    res_valid;
  result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_samples  <= MAX_SAMPLES_RST;
      cfg_q.filter_shift <= FILTER_SHIFT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_SAMPLES:  cfg_q.max_samples  <= cfg_data_i;
        CFG_FILTER_SHIFT: cfg_q.filter_shift <= cfg_data_i[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dcbl_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .sample_in_i     (sample_in_i),
    .last_in_block_i (last_in_block_i),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .item_pop_i      (item_pop)
  );

  dcbl_back #(
    .BLOCK_MAX (BLOCK_MAX)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop)
  );

  assign empty             = !res_valid;
  assign filtered_sample_o = res.filtered_sample;
  assign stored_o          = res.stored;
  assign write_index_o     = res.write_index;
  assign level_valid_o     = res.level_valid;
  assign level_o           = res.level;
  assign peak_o            = res.peak;
  assign limit_reached_o   = res.limit_reached;
  assign recording_o       = res.recording;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dc blocker / level meter / capture core. A
// directed table walks reset behavior, extreme samples, every command and the
// limit and shift corner settings. Random phases follow, each reprogramming
// both registers while the core is idle and sending blocks of samples with
// some command noise. Each popped result is checked field by field against a
// table entry or cycle-free model of filter, block meter, capture addressing.
// ----------------------------------------------------------------------------
module tb;

  import dcbl_pkg::*;

  localparam int unsigned BLOCK_LEN = BLOCK_MAX_DEFAULT;

  logic                       clk_i     = 1'b0;
  logic                       rst_ni    = 1'b0;
  logic                       cfg_valid = 1'b0;
  cfg_idx_e                   cfg_index = CFG_MAX_SAMPLES;
  logic [IDX_W-1:0]           cfg_data  = '0;
  logic                       push      = 1'b0;
  cmd_e                       command   = CMD_SAMPLE;
  logic signed [SAMPLE_W-1:0] sample_drv = '0;
  logic                       last_drv  = 1'b0;
  logic                       pop       = 1'b0;

  logic                       cfg_ready;
  logic                       full;
  logic                       empty;
  logic signed [SAMPLE_W-1:0] filtered_sample;
  logic                       stored;
  logic [IDX_W-1:0]           write_index;
  logic                       level_valid;
  logic [SAMPLE_W-1:0]        level;
  logic [SAMPLE_W-1:0]        peak;
  logic                       limit_reached;
  logic                       recording;

  dc_blocker_level_meter_capture_core #(
    .BLOCK_MAX(BLOCK_LEN)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .push             (push),
    .full             (full),
    .command_i        (command),
    .sample_in_i      (sample_drv),
    .last_in_block_i  (last_drv),
    .empty            (empty),
    .pop              (pop),
    .filtered_sample_o(filtered_sample),
    .stored_o         (stored),
    .write_index_o    (write_index),
    .level_valid_o    (level_valid),
    .level_o          (level),
    .peak_o           (peak),
    .limit_reached_o  (limit_reached),
    .recording_o      (recording)
  );

  always #5 clk_i = ~clk_i;

  // model state and register copies
  logic [ACC_W-1:0]   fb_in;
  logic [ACC_W-1:0]   fb_out;
  logic [SUM_W-1:0]   blk_sum;
  logic [15:0]        blk_peak;
  logic [8:0]         blk_cnt;
  logic [IDX_W-1:0]   wr_count;
  logic               rec_on;
  logic               lim_on;
  logic [IDX_W-1:0]   reg_max   = MAX_SAMPLES_RST;
  logic [SHIFT_W-1:0] reg_shift = FILTER_SHIFT_RST;

  result_t pending_results[$];
  int      n_errors      = 0;
  int      n_sent        = 0;
  int      burst_left    = 0;
  bit      steady        = 1'b0;
  bit      hold_req      = 1'b0;
  int      dc_level      = 0;
  int      noise_amp     = 100;

  typedef struct {
    bit                         is_reg;
    cfg_idx_e                   idx;
    logic [IDX_W-1:0]           data;
    cmd_e                       cmd;
    logic signed [SAMPLE_W-1:0] smp;
    logic                       last;
    bit                         fixed;
    result_t                    exp;
  } stim_row_t;

  stim_row_t stim_tab[$];

  function automatic void clear_capture();
    fb_in    = '0;
    fb_out   = '0;
    blk_sum  = '0;
    blk_peak = '0;
    blk_cnt  = '0;
    wr_count = '0;
    rec_on   = 1'b0;
    lim_on   = 1'b0;
  endfunction

  function automatic result_t predict_capture(cmd_e c, logic signed [SAMPLE_W-1:0] s, logic l);
    result_t          r;
    logic [ACC_W-1:0] x;
    logic [ACC_W-1:0] y;
    logic [ACC_W-1:0] pcm;
    logic [15:0]      f;
    logic [16:0]      mag;
    logic [SUM_W:0]   sum_n;
    r = '0;
    case (c)
      CMD_START: begin
        clear_capture();
        rec_on = 1'b1;
      end
      CMD_STOP: rec_on = 1'b0;
      CMD_SAMPLE: begin
        if (rec_on) begin
          x   = {s, 16'h0000};
          y   = x - fb_in + (fb_out - ACC_W'($signed(fb_out) >>> reg_shift));
          pcm = ACC_W'($signed(y) >>> 16);
          fb_in  = x;
          fb_out = y;
          f   = pcm[15:0];
          mag = f[15] ? (17'h10000 - {1'b0, f}) : {1'b0, f};
          r.filtered_sample = f;
          sum_n = {1'b0, blk_sum} + mag;
          blk_sum = (sum_n > 25'hFFFFFF) ? 24'hFFFFFF : sum_n[SUM_W-1:0];
          if (mag > blk_peak) blk_peak = mag[15:0];
          blk_cnt++;
          if (l || blk_cnt >= BLOCK_LEN) begin
            r.level_valid = 1'b1;
            r.level       = 16'(blk_sum / blk_cnt);
            r.peak        = blk_peak;
            blk_sum  = '0;
            blk_peak = '0;
            blk_cnt  = '0;
          end
          if (wr_count < reg_max) begin
            r.stored      = 1'b1;
            r.write_index = wr_count;
            wr_count      = wr_count + 1'b1;
          end
          if (wr_count >= reg_max) begin
            lim_on = 1'b1;
            rec_on = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.limit_reached = lim_on;
    r.recording     = rec_on;
    return r;
  endfunction

  function automatic result_t flags_only(bit lim, bit rec);
    result_t r;
    r = '0;
    r.limit_reached = lim;
    r.recording     = rec;
    return r;
  endfunction

  function automatic stim_row_t blank_row();
    stim_row_t row;
    row.is_reg = 1'b0;
    row.idx    = CFG_MAX_SAMPLES;
    row.data   = '0;
    row.cmd    = CMD_SAMPLE;
    row.smp    = '0;
    row.last   = 1'b0;
    row.fixed  = 1'b0;
    row.exp    = '0;
    return row;
  endfunction

  function automatic void tab_item(cmd_e c, logic signed [SAMPLE_W-1:0] s, logic l);
    stim_row_t row;
    row = blank_row();
    row.cmd  = c;
    row.smp  = s;
    row.last = l;
    stim_tab.push_back(row);
  endfunction

  function automatic void tab_fixed(cmd_e c, logic signed [SAMPLE_W-1:0] s, logic l,
                                    result_t e);
    stim_row_t row;
    row = blank_row();
    row.cmd   = c;
    row.smp   = s;
    row.last  = l;
    row.fixed = 1'b1;
    row.exp   = e;
    stim_tab.push_back(row);
  endfunction

  function automatic void tab_reg(cfg_idx_e i, logic [IDX_W-1:0] d);
    stim_row_t row;
    row = blank_row();
    row.is_reg = 1'b1;
    row.idx    = i;
    row.data   = d;
    stim_tab.push_back(row);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = 32767;
      1: v = -32768;
      2, 3: v = int'($signed(16'($urandom)));
      default: v = dc_level + int'($urandom_range(0, 2 * noise_amp)) - noise_amp;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic note_error(string msg);
    n_errors++;
    if (n_errors <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (a !== e) note_error($sformatf("%s expected %h got %h", name, e, a));
  endtask

  task automatic send_item(cmd_e c, logic signed [SAMPLE_W-1:0] s, logic l,
                           bit fixed, result_t fixed_exp);
    int      gap;
    result_t r;
    if (!steady && burst_left == 0) begin
      gap        = $urandom_range(0, 12);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        @(negedge clk_i);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    push       <= 1'b1;
    command    <= c;
    sample_drv <= s;
    last_drv   <= l;
    do @(posedge clk_i); while (full);
    n_sent++;
    r = predict_capture(c, s, l);
    pending_results.push_back(fixed ? fixed_exp : r);
  endtask

  task automatic send(cmd_e c, logic signed [SAMPLE_W-1:0] s, logic l);
    send_item(c, s, l, 1'b0, '0);
  endtask

  // only while idle: every expected result has been popped
  task automatic write_reg(cfg_idx_e idx, logic [IDX_W-1:0] d);
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == CFG_MAX_SAMPLES) reg_max = d;
    else reg_shift = d[SHIFT_W-1:0];
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        note_error("result with nothing expected");
      end else begin
        e = pending_results.pop_front();
        check_field("filtered_sample", e.filtered_sample, filtered_sample);
        check_field("stored", e.stored, stored);
        check_field("write_index", e.write_index, write_index);
        check_field("level_valid", e.level_valid, level_valid);
        check_field("level", e.level, level);
        check_field("peak", e.peak, peak);
        check_field("limit_reached", e.limit_reached, limit_reached);
        check_field("recording", e.recording, recording);
      end
    end
  end

  // receiver stall pattern
  initial begin : receiver
    int mode;
    int left;
    int k;
    mode = 0;
    left = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        for (k = 0; k < 300; k++) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(40, 160);
      end
      left--;
      case (mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 2) == 0);
        default: pop <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin : stimulus
    int               ph;
    int               b;
    int               k;
    int               nblk;
    int               len;
    bit               lower_max;
    logic [IDX_W-1:0] mx;
    logic [3:0]       sh;
    clear_capture();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    tab_fixed(CMD_SAMPLE, 16'sh1234, 1'b1, flags_only(0, 0));
    tab_fixed(CMD_NONE, 16'shFFFF, 1'b1, flags_only(0, 0));
    tab_fixed(CMD_STOP, 16'sh0000, 1'b0, flags_only(0, 0));
    tab_fixed(CMD_START, 16'sh7FFF, 1'b1, flags_only(0, 1));
    tab_item(CMD_SAMPLE, 16'sh7FFF, 1'b0);
    tab_item(CMD_SAMPLE, 16'sh8000, 1'b0);
    tab_item(CMD_SAMPLE, 16'sh8000, 1'b1);
    tab_item(CMD_SAMPLE, 16'sh0000, 1'b1);
    tab_item(CMD_SAMPLE, 16'sh7FFF, 1'b1);
    tab_item(CMD_NONE, 16'sh5555, 1'b0);
    tab_item(CMD_SAMPLE, 16'shFFFF, 1'b0);
    tab_fixed(CMD_STOP, 16'shAAAA, 1'b1, flags_only(0, 0));
    tab_fixed(CMD_SAMPLE, 16'sh0064, 1'b1, flags_only(0, 0));
    tab_reg(CFG_FILTER_SHIFT, 20'd0);
    tab_fixed(CMD_START, 16'sh0000, 1'b0, flags_only(0, 1));
    tab_item(CMD_SAMPLE, 16'sh7FFF, 1'b0);
    tab_item(CMD_SAMPLE, 16'sh8000, 1'b1);
    tab_reg(CFG_FILTER_SHIFT, 20'd15);
    tab_reg(CFG_MAX_SAMPLES, 20'd1);
    tab_fixed(CMD_START, 16'sh0F0F, 1'b1, flags_only(0, 1));
    tab_item(CMD_SAMPLE, 16'sh1388, 1'b0);
    tab_fixed(CMD_SAMPLE, 16'sh0007, 1'b1, flags_only(1, 0));
    tab_reg(CFG_MAX_SAMPLES, 20'd0);
    tab_fixed(CMD_START, 16'sh0000, 1'b0, flags_only(0, 1));
    tab_item(CMD_SAMPLE, 16'shB1E0, 1'b1);
    tab_reg(CFG_MAX_SAMPLES, 20'hFFFFF);
    tab_reg(CFG_FILTER_SHIFT, 20'd1);
    tab_fixed(CMD_START, 16'sh0000, 1'b0, flags_only(0, 1));
    tab_item(CMD_SAMPLE, 16'sh7FFF, 1'b1);

    foreach (stim_tab[i]) begin
      if (stim_tab[i].is_reg) write_reg(stim_tab[i].idx, stim_tab[i].data);
      else send_item(stim_tab[i].cmd, stim_tab[i].smp, stim_tab[i].last,
                     stim_tab[i].fixed, stim_tab[i].exp);
    end

    ph = 0;
    while (n_sent < 600) begin
      case ($urandom_range(0, 5))
        0: sh = 4'd1;
        1: sh = 4'd15;
        2: sh = 4'd0;
        default: sh = 4'($urandom_range(1, 15));
      endcase
      case ($urandom_range(0, 7))
        0: mx = 20'($urandom_range(1, 40));
        1: mx = 20'hFFFFF;
        2: mx = 20'd0;
        3: mx = 20'($urandom_range(41, 600));
        default: mx = 20'($urandom_range(600, 20'hFFFFF));
      endcase
      if (ph == 0) mx = 20'hFFFFF;
      write_reg(CFG_FILTER_SHIFT, {16'h0, sh});
      write_reg(CFG_MAX_SAMPLES, mx);
      steady    = ($urandom_range(0, 4) == 0);
      lower_max = ($urandom_range(0, 5) == 0);
      dc_level  = int'($urandom_range(0, 60000)) - 30000;
      noise_amp = $urandom_range(1, 4000);
      if (ph == 0 || $urandom_range(0, 7) != 0) send(CMD_START, 16'($urandom), 1'($urandom));
      // long receiver hold-off while the sender keeps pushing
      if (ph == 0) hold_req = 1'b1;
      nblk = $urandom_range(2, 6);
      for (b = 0; b < nblk && n_sent < 600; b++) begin
        if ((ph == 0 && b == 0) || $urandom_range(0, 11) == 0) len = $urandom_range(250, 300);
        else len = $urandom_range(1, 24);
        for (k = 0; k < len; k++) begin
          case ($urandom_range(0, 59))
            0: send(CMD_NONE, 16'($urandom), 1'($urandom));
            1: begin
              send(CMD_STOP, 16'($urandom), 1'($urandom));
              if ($urandom_range(0, 1) == 0) send(CMD_START, 16'($urandom), 1'($urandom));
            end
            default: ;
          endcase
          send(CMD_SAMPLE, pick_sample(), (k == len - 1) || ($urandom_range(0, 49) == 0));
        end
        // lower the limit to at most the count while recording
        if (b == 0 && lower_max) write_reg(CFG_MAX_SAMPLES, 20'($urandom_range(0, wr_count)));
      end
      ph++;
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/dcbl_pkg.sv
hdl/dcbl_front.sv
hdl/dcbl_div.sv
hdl/dcbl_back.sv
hdl/dc_blocker_level_meter_capture_core.sv
test/tb.sv
